[design/mmac_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate package
// Shared types, codes and widths for the controller, datapath and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mmac_pkg;

  // Dimension counters and the size register.
  localparam int unsigned DIM_W = 4;
  localparam logic [DIM_W-1:0] SIZE_RESET = 4'd8;

  // Field widths of the stream items.
  localparam int unsigned IDX_W = 3;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned C_W = 40;
  localparam int unsigned PROD_W = 2 * VAL_W;
  // Exact sum of one C element and up to fifteen products needs 41 bits.
  localparam int unsigned ACC_W = 42;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 48;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_we;
    op_e              load_op;
    logic             mac_rd;
    logic             mac_first;
    logic             mac_last;
    logic             wb;
    logic             wb_last;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] kk;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/matrix_multiply_accumulate_top.sv]
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate top level
// Computes C += A * B on square matrices of dimension n up to MAX_DIM.
// ----------------------------------------------------------------------------
// Load items (tuser = load A, B or C) write one element each and are taken one
// per cycle while no compute runs; a load outside the current n is dropped,
// and a C load is scaled from Q2.14 to Q12.28. A compute item streams all n*n
// C elements in row-major order, the final one with tlast, each value being
// C + sum A[i][k]*B[k][j], saturated to 40 bits and written back to C. The
// shared multiplier and accumulator handle one element at a time, reading one
// A and one B element per cycle from the element memories; an element waits
// for write-back while the output is stalled. Input is not taken until the
// last element has been handed to the output register. C is all zero after
// reset; A and B hold nothing defined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_accumulate_top #(
  parameter int MAX_DIM = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [3:0]  cfg_wdata_i,    // size_in_use
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,   // row_index, col_index, element_value, zero pad
  input  wire  [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_row, out_col, product_value, zero pad
  output logic        m_axis_tlast    // last_element
);

  mmac_pkg::cmd_t cmd;
  mmac_pkg::sts_t sts;
  logic [mmac_pkg::IDX_W-1:0]        out_row, out_col;
  logic signed [mmac_pkg::C_W-1:0]   out_value;

  mmac_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (mmac_pkg::op_e'(s_axis_tuser)),
    .in_row_i   (s_axis_tdata[2:0]),
    .in_col_i   (s_axis_tdata[5:3]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmac_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_row_i   (s_axis_tdata[2:0]),
    .in_col_i   (s_axis_tdata[5:3]),
    .in_value_i (s_axis_tdata[21:6]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_value_o(out_value),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule

`default_nettype wire

[design/mmac_ctrl.sv]
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate controller
// Holds the size register, steps through rows, columns and the inner index,
// and issues load, multiply-accumulate and write-back commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmac_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [mmac_pkg::DIM_W-1:0]    cfg_wdata_i,
  input  wire                           in_valid_i,
  input  mmac_pkg::op_e                 in_op_i,
  input  wire  [mmac_pkg::IDX_W-1:0]    in_row_i,
  input  wire  [mmac_pkg::IDX_W-1:0]    in_col_i,
  output logic                          in_ready_o,
  input  mmac_pkg::sts_t                sts_i,
  output mmac_pkg::cmd_t                cmd_o
);

  mmac_pkg::state_e state_q, state_d;
  logic [mmac_pkg::DIM_W-1:0] size_q;
  logic [mmac_pkg::DIM_W-1:0] dim;
  logic [mmac_pkg::DIM_W-1:0] i_q, j_q, k_q;
  logic accept, in_range, k_end, j_end, i_end;

  always_comb begin
    dim = size_q;
    if (size_q == '0) begin
      dim = mmac_pkg::DIM_W'(1);
    end else if (32'(size_q) > MAX_DIM) begin
      dim = mmac_pkg::DIM_W'(MAX_DIM);
    end
  end

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = (mmac_pkg::DIM_W'(in_row_i) < dim) && (mmac_pkg::DIM_W'(in_col_i) < dim);
  assign k_end    = (k_q == dim - 1'b1);
  assign j_end    = (j_q == dim - 1'b1);
  assign i_end    = (i_q == dim - 1'b1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmac_pkg::ST_IDLE: begin
        if (accept && in_op_i == mmac_pkg::OP_COMPUTE) state_d = mmac_pkg::ST_MAC;
      end
      mmac_pkg::ST_MAC: begin
        if (k_end) state_d = mmac_pkg::ST_DRAIN;
      end
      mmac_pkg::ST_DRAIN: begin
        if (cmd_o.wb) state_d = (i_end && j_end) ? mmac_pkg::ST_IDLE : mmac_pkg::ST_MAC;
      end
      default: state_d = mmac_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o        = (state_q == mmac_pkg::ST_IDLE);
    cmd_o.load_we     = accept && (in_op_i != mmac_pkg::OP_COMPUTE) && in_range;
    cmd_o.load_op     = in_op_i;
    cmd_o.mac_rd      = (state_q == mmac_pkg::ST_MAC);
    cmd_o.mac_first   = (k_q == '0);
    cmd_o.mac_last    = k_end;
    cmd_o.wb          = (state_q == mmac_pkg::ST_DRAIN) && sts_i.acc_done && sts_i.out_free;
    cmd_o.wb_last     = i_end && j_end;
    cmd_o.row         = i_q;
    cmd_o.col         = j_q;
    cmd_o.kk          = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmac_pkg::ST_IDLE;
      size_q  <= mmac_pkg::SIZE_RESET;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (state_q == mmac_pkg::ST_IDLE) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (state_q == mmac_pkg::ST_MAC) begin
        k_q <= k_end ? '0 : k_q + 1'b1;
      end else if (cmd_o.wb) begin
        if (j_end) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/mmac_dp.sv]
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate datapath
// Element memories for A, B and C, a registered multiplier, the exact
// accumulator with saturation, and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmac_dp #(
  parameter int MAX_DIM = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  mmac_pkg::cmd_t                       cmd_i,
  output mmac_pkg::sts_t                       sts_o,
  input  wire  [mmac_pkg::IDX_W-1:0]           in_row_i,
  input  wire  [mmac_pkg::IDX_W-1:0]           in_col_i,
  input  wire  signed [mmac_pkg::VAL_W-1:0]    in_value_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [mmac_pkg::IDX_W-1:0]           out_row_o,
  output logic [mmac_pkg::IDX_W-1:0]           out_col_o,
  output logic signed [mmac_pkg::C_W-1:0]      out_value_o,
  output logic                                 out_last_o
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int EXT_W = mmac_pkg::C_W - mmac_pkg::VAL_W - mmac_pkg::FRAC_SHIFT;

  logic signed [mmac_pkg::VAL_W-1:0] mem_a [CELLS];
  logic signed [mmac_pkg::VAL_W-1:0] mem_b [CELLS];
  logic signed [mmac_pkg::C_W-1:0]   mem_c [CELLS];
  logic [CELLS-1:0]                  c_vld_q;

  logic [CAW-1:0] ld_addr, a_addr, b_addr, c_addr, cw_addr;
  logic           cw_en;
  logic signed [mmac_pkg::C_W-1:0] cw_data, ld_c_val, sat_val;

  logic signed [mmac_pkg::VAL_W-1:0]  a_rd_q, b_rd_q;
  logic signed [mmac_pkg::C_W-1:0]    c_rd_q;
  logic                               c_vld_rd_q;
  logic signed [mmac_pkg::PROD_W-1:0] prod_q;
  logic signed [mmac_pkg::ACC_W-1:0]  acc_q;
  logic s1_vld_q, s1_first_q, s1_last_q, s2_vld_q, s2_last_q, acc_done_q;

  assign ld_addr = CAW'(32'(in_row_i) * MAX_DIM + 32'(in_col_i));
  assign a_addr  = CAW'(32'(cmd_i.row) * MAX_DIM + 32'(cmd_i.kk));
  assign b_addr  = CAW'(32'(cmd_i.kk) * MAX_DIM + 32'(cmd_i.col));
  assign c_addr  = CAW'(32'(cmd_i.row) * MAX_DIM + 32'(cmd_i.col));

  assign ld_c_val = {{EXT_W{in_value_i[mmac_pkg::VAL_W-1]}}, in_value_i,
                     {mmac_pkg::FRAC_SHIFT{1'b0}}};

  // Saturate once: the sum fits 40 bits exactly when its top bits agree.
  always_comb begin
    if (acc_q[mmac_pkg::ACC_W-1:mmac_pkg::C_W-1] == '0 ||
        acc_q[mmac_pkg::ACC_W-1:mmac_pkg::C_W-1] == '1) begin
      sat_val = acc_q[mmac_pkg::C_W-1:0];
    end else if (acc_q[mmac_pkg::ACC_W-1]) begin
      sat_val = {1'b1, {(mmac_pkg::C_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(mmac_pkg::C_W-1){1'b1}}};
    end
  end

  assign cw_en   = cmd_i.wb || (cmd_i.load_we && cmd_i.load_op == mmac_pkg::OP_LOAD_C);
  assign cw_addr = cmd_i.wb ? c_addr : ld_addr;
  assign cw_data = cmd_i.wb ? sat_val : ld_c_val;

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && cmd_i.load_op == mmac_pkg::OP_LOAD_A) mem_a[ld_addr] <= in_value_i;
    if (cmd_i.load_we && cmd_i.load_op == mmac_pkg::OP_LOAD_B) mem_b[ld_addr] <= in_value_i;
    if (cw_en) mem_c[cw_addr] <= cw_data;
    if (cmd_i.mac_rd) begin
      a_rd_q <= mem_a[a_addr];
      b_rd_q <= mem_b[b_addr];
      c_rd_q <= mem_c[c_addr];
    end
  end

  // Payload stages of the multiply-accumulate.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) prod_q <= a_rd_q * b_rd_q;
    if (s1_vld_q && s1_first_q) begin
      acc_q <= c_vld_rd_q ? mmac_pkg::ACC_W'(c_rd_q) : '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + mmac_pkg::ACC_W'(prod_q);
    end
    if (cmd_i.wb) begin
      out_row_o   <= mmac_pkg::IDX_W'(cmd_i.row);
      out_col_o   <= mmac_pkg::IDX_W'(cmd_i.col);
      out_value_o <= sat_val;
      out_last_o  <= cmd_i.wb_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q     <= '0;
      c_vld_rd_q  <= 1'b0;
      s1_vld_q    <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_last_q   <= 1'b0;
      acc_done_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cw_en) c_vld_q[cw_addr] <= 1'b1;
      if (cmd_i.mac_rd) c_vld_rd_q <= c_vld_q[c_addr];
      s1_vld_q   <= cmd_i.mac_rd;
      s1_first_q <= cmd_i.mac_first;
      s1_last_q  <= cmd_i.mac_last;
      s2_vld_q   <= s1_vld_q;
      s2_last_q  <= s1_vld_q && s1_last_q;
      if (s2_vld_q && s2_last_q) begin
        acc_done_q <= 1'b1;
      end else if (cmd_i.wb) begin
        acc_done_q <= 1'b0;
      end
      if (cmd_i.wb) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign sts_o.acc_done = acc_done_q;
  assign sts_o.out_free = !out_valid_o || out_ready_i;

endmodule

`default_nettype wire

[design/mmac_checker.sv]
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate port checker
// Watches the top level's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mmac_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [1:0]  s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire        m_axis_tlast
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // An idle block with an empty output never raises a result on its own.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result item without a compute");

  a_load_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser != mmac_pkg::OP_COMPUTE |=> s_axis_tready)
    else $error("load item stopped intake");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tuser == mmac_pkg::OP_COMPUTE |=> !s_axis_tready)
    else $error("compute item did not stop intake");

endmodule

bind matrix_multiply_accumulate_top mmac_checker u_mmac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Matrix multiply-accumulate testbench
// Drives load and compute items into the block and predicts C += A * B in
// 40-bit saturating fixed point. Every streamed C element is checked against
// the prediction, under random stalls on both sides, size changes and long
// output hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DIM = 8;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam longint C_HI = (longint'(1) <<< (mmac_pkg::C_W - 1)) - 1;
  localparam longint C_LO = -(longint'(1) <<< (mmac_pkg::C_W - 1));

  typedef struct {
    logic [mmac_pkg::IDX_W-1:0]      row;
    logic [mmac_pkg::IDX_W-1:0]      col;
    logic signed [mmac_pkg::C_W-1:0] value;
    logic                            last;
  } c_elem_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;   // row_index, col_index, element_value, zero pad
  logic [1:0]  s_axis_tuser = 2'd0;    // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // out_row, out_col, product_value, zero pad
  logic        m_axis_tlast;           // last_element

  // Predicted block state.
  logic signed [mmac_pkg::VAL_W-1:0] a_store [CELLS] = '{default: '0};
  logic signed [mmac_pkg::VAL_W-1:0] b_store [CELLS] = '{default: '0};
  logic signed [mmac_pkg::C_W-1:0]   c_store [CELLS] = '{default: '0};
  logic [3:0]                        size_q = mmac_pkg::SIZE_RESET;
  c_elem_t                           pending_elems [$];

  // Stimulus bookkeeping: which A and B elements hold a written value.
  bit          a_set [CELLS];
  bit          b_set [CELLS];
  int unsigned cur_n = MAX_DIM;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned holds_req = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  matrix_multiply_accumulate_top #(
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned dim_of(logic [3:0] s);
    if (s == 4'd0) return 1;
    if (s > MAX_DIM) return MAX_DIM;
    return 32'(s);
  endfunction

  // Applies one accepted item to the predicted state and queues any C elements.
  function automatic void apply_item(mmac_pkg::op_e op, logic [mmac_pkg::IDX_W-1:0] r,
                                     logic [mmac_pkg::IDX_W-1:0] c,
                                     logic signed [mmac_pkg::VAL_W-1:0] v);
    int unsigned n;
    longint acc;
    c_elem_t elem;
    n = dim_of(size_q);
    if (op != mmac_pkg::OP_COMPUTE) begin
      if (r >= n || c >= n) return;
      case (op)
        mmac_pkg::OP_LOAD_A: a_store[r * MAX_DIM + c] = v;
        mmac_pkg::OP_LOAD_B: b_store[r * MAX_DIM + c] = v;
        default: c_store[r * MAX_DIM + c] =
                   mmac_pkg::C_W'(longint'(v) <<< mmac_pkg::FRAC_SHIFT);
      endcase
      return;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = longint'(c_store[i * MAX_DIM + j]);
        for (int k = 0; k < n; k++)
          acc += longint'(a_store[i * MAX_DIM + k]) * longint'(b_store[k * MAX_DIM + j]);
        if (acc > C_HI) acc = C_HI;
        if (acc < C_LO) acc = C_LO;
        c_store[i * MAX_DIM + j] = mmac_pkg::C_W'(acc);
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        elem.row = mmac_pkg::IDX_W'(i);
        elem.col = mmac_pkg::IDX_W'(j);
        elem.value = c_store[i * MAX_DIM + j];
        elem.last = (i == n - 1) && (j == n - 1);
        pending_elems.push_back(elem);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_elem();
    c_elem_t want;
    logic [mmac_pkg::IDX_W-1:0] got_row;
    logic [mmac_pkg::IDX_W-1:0] got_col;
    logic signed [mmac_pkg::C_W-1:0] got_val;
    got_row = m_axis_tdata[2:0];
    got_col = m_axis_tdata[5:3];
    got_val = m_axis_tdata[45:6];
    if (pending_elems.size() == 0) begin
      report_mismatch($sformatf("unexpected element row %0d col %0d value %0d",
                                got_row, got_col, got_val));
      return;
    end
    want = pending_elems.pop_front();
    if (got_row !== want.row)
      report_mismatch($sformatf("row %0d, expected %0d", got_row, want.row));
    if (got_col !== want.col)
      report_mismatch($sformatf("col %0d, expected %0d", got_col, want.col));
    if (got_val !== want.value)
      report_mismatch($sformatf("C[%0d][%0d] = %0d, expected %0d",
                                want.row, want.col, got_val, want.value));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("last flag %b at C[%0d][%0d], expected %b",
                                m_axis_tlast, want.row, want.col, want.last));
  endtask

  // Observes the configuration port and both handshakes at every edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) size_q = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        apply_item(mmac_pkg::op_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[5:3],
                   s_axis_tdata[21:6]);
      if (m_axis_tvalid && m_axis_tready) check_elem();
    end
  end

  // Output side: random stalls, plus a long hold-off whenever a test asks.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holds_req != holds_done) begin
      holds_done <= holds_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [mmac_pkg::VAL_W-1:0] rand_val();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return mmac_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Offers one item, with a random gap first, and returns at its acceptance edge.
  task automatic send_item(input mmac_pkg::op_e op, input int unsigned r,
                           input int unsigned c,
                           input logic signed [mmac_pkg::VAL_W-1:0] v);
    bit in_range;
    in_range = (r < cur_n) && (c < cur_n);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {2'b00, v, mmac_pkg::IDX_W'(c), mmac_pkg::IDX_W'(r)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (in_range && op == mmac_pkg::OP_LOAD_A) a_set[r * MAX_DIM + c] = 1'b1;
    if (in_range && op == mmac_pkg::OP_LOAD_B) b_set[r * MAX_DIM + c] = 1'b1;
  endtask

  // A and B elements are loaded before any compute may read them.
  task automatic compute_c();
    for (int unsigned r = 0; r < cur_n; r++)
      for (int unsigned c = 0; c < cur_n; c++)
        if (!a_set[r * MAX_DIM + c]) send_item(mmac_pkg::OP_LOAD_A, r, c, rand_val());
    for (int unsigned r = 0; r < cur_n; r++)
      for (int unsigned c = 0; c < cur_n; c++)
        if (!b_set[r * MAX_DIM + c]) send_item(mmac_pkg::OP_LOAD_B, r, c, rand_val());
    send_item(mmac_pkg::OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
              mmac_pkg::VAL_W'($urandom));
  endtask

  // The first edge lets the observer take in an item accepted at the last one.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_size(input logic [3:0] s);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_n = dim_of(s);
  endtask

  task automatic test_directed();
    set_size(4'd2);
    send_item(mmac_pkg::OP_LOAD_A, 0, 0, 16'sh7FFF);
    send_item(mmac_pkg::OP_LOAD_A, 0, 1, 16'sh8000);
    send_item(mmac_pkg::OP_LOAD_A, 1, 0, 16'sh0000);
    send_item(mmac_pkg::OP_LOAD_A, 1, 1, 16'shFFFF);
    send_item(mmac_pkg::OP_LOAD_B, 0, 0, 16'sh8000);
    send_item(mmac_pkg::OP_LOAD_B, 0, 1, 16'sh7FFF);
    send_item(mmac_pkg::OP_LOAD_B, 1, 0, 16'sh0001);
    send_item(mmac_pkg::OP_LOAD_B, 1, 1, 16'sh8000);
    send_item(mmac_pkg::OP_LOAD_C, 0, 0, 16'sh8000);
    send_item(mmac_pkg::OP_LOAD_C, 1, 1, 16'sh7FFF);
    // Loads outside the current size are dropped.
    send_item(mmac_pkg::OP_LOAD_A, 2, 0, 16'sh1234);
    send_item(mmac_pkg::OP_LOAD_B, 0, 7, 16'sh4321);
    send_item(mmac_pkg::OP_LOAD_C, 7, 7, 16'sh7FFF);
    send_item(mmac_pkg::OP_COMPUTE, 7, 7, 16'shFFFF);
    // A size of zero behaves as one.
    set_size(4'd0);
    send_item(mmac_pkg::OP_LOAD_A, 0, 0, 16'sh8000);
    send_item(mmac_pkg::OP_LOAD_B, 0, 0, 16'sh8000);
    send_item(mmac_pkg::OP_LOAD_C, 1, 0, 16'sh7FFF);
    send_item(mmac_pkg::OP_COMPUTE, 0, 0, 16'sh0000);
    set_size(4'd1);
    send_item(mmac_pkg::OP_COMPUTE, 5, 2, 16'sh5555);
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    mmac_pkg::op_e op;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) set_size(4'($urandom_range(1, 4)));
      else if (pick < 16) set_size(4'd0);
      else if (pick < 18) set_size(4'($urandom_range(5, 6)));
      if ($urandom_range(0, 3) != 0) begin
        for (int unsigned r = 0; r < cur_n; r++)
          for (int unsigned c = 0; c < cur_n; c++)
            send_item(mmac_pkg::OP_LOAD_A, r, c, rand_val());
        for (int unsigned r = 0; r < cur_n; r++)
          for (int unsigned c = 0; c < cur_n; c++)
            send_item(mmac_pkg::OP_LOAD_B, r, c, rand_val());
        if ($urandom_range(0, 1) != 0)
          repeat ($urandom_range(1, cur_n))
            send_item(mmac_pkg::OP_LOAD_C, $urandom_range(0, cur_n - 1),
                      $urandom_range(0, cur_n - 1), rand_val());
        if (cur_n < MAX_DIM)
          repeat ($urandom_range(0, 2))
            send_item(mmac_pkg::op_e'($urandom_range(0, 2)),
                      $urandom_range(cur_n, MAX_DIM - 1),
                      $urandom_range(0, MAX_DIM - 1), rand_val());
        compute_c();
        if ($urandom_range(0, 2) == 0) compute_c();
      end else begin
        // Loose items in any order, with any indexes.
        repeat ($urandom_range(1, 6)) begin
          op = mmac_pkg::op_e'($urandom_range(0, 3));
          if (op == mmac_pkg::OP_COMPUTE) compute_c();
          else send_item(op, $urandom_range(0, 7), $urandom_range(0, 7), rand_val());
        end
      end
    end
  endtask

  // The output is held off while a compute and further loads are offered, so
  // the block fills up and stalls its input.
  task automatic test_pressure();
    set_size(4'd8);
    compute_c();
    holds_req <= holds_req + 1;
    compute_c();
    repeat (10)
      send_item(mmac_pkg::OP_LOAD_C, $urandom_range(0, 7), $urandom_range(0, 7),
                rand_val());
    compute_c();
    wait_idle();
    send_item(mmac_pkg::OP_LOAD_A, 7, 7, rand_val());
    compute_c();
  endtask

  // Repeated accumulation at the full size drives C[0][0] into the upper
  // limit and C[1][0] into the lower one; an oversized setting acts as eight.
  task automatic test_saturation();
    set_size(4'd15);
    for (int unsigned k = 0; k < cur_n; k++) begin
      send_item(mmac_pkg::OP_LOAD_A, 0, k, 16'sh8000);
      send_item(mmac_pkg::OP_LOAD_A, 1, k, 16'sh7FFF);
      send_item(mmac_pkg::OP_LOAD_B, k, 0, 16'sh8000);
    end
    send_item(mmac_pkg::OP_LOAD_C, 0, 0, 16'sh7FFF);
    send_item(mmac_pkg::OP_LOAD_C, 1, 0, 16'sh8000);
    repeat (66) compute_c();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 14;
    rx_idle_pct = 69;
    test_directed();
    test_random(20);
    tx_idle_pct = 69;
    rx_idle_pct = 14;
    test_random(20);
    test_pressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_saturation();
    test_random(10);
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mmac_pkg.sv
design/mmac_ctrl.sv
design/mmac_dp.sv
design/matrix_multiply_accumulate_top.sv
design/mmac_checker.sv
tb/tb_top.sv
